/* hw/rtl/preemptive_priority_scheduler_macros.svh */
// assertion helpers used by the scheduler rtl
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PPS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/pps_pkg.sv */
package pps_pkg;

   // priority field width, fixed by the item format
   localparam int PRIO_BITS = 8;

   // request function codes
   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_TICK = 1'b1
   } func_type;

   // control from the table scan to the selector
   typedef struct packed {
      logic clear;
      logic cand;
   } scan_ctl_type;

endpackage

/* hw/rtl/pps_select.sv */
module pps_select #(
   parameter int SLOT_BITS = 4,
   parameter int TIME_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pps_pkg::scan_ctl_type          ctl,
   input  logic [SLOT_BITS-1:0]           cand_slot,
   input  logic [pps_pkg::PRIO_BITS-1:0]  cand_prio,
   input  logic [TIME_BITS-1:0]           cand_eff,
   output logic                           take,
   output logic                           found,
   output logic [SLOT_BITS-1:0]           best_slot
);
   import pps_pkg::*;

   logic                 found_ff;
   logic [SLOT_BITS-1:0] slot_ff;
   logic [PRIO_BITS-1:0] prio_ff;
   logic [TIME_BITS-1:0] eff_ff;

   // lower priority number wins, then earlier effective arrival, then lower slot
   assign take = ctl.cand && (!found_ff || (cand_prio < prio_ff) ||
                 ((cand_prio == prio_ff) && (cand_eff < eff_ff)));

   // found flag
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl.clear) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   // best candidate so far
   always_ff @(posedge clock) begin
      if (take) begin
         slot_ff <= cand_slot;
         prio_ff <= cand_prio;
         eff_ff  <= cand_eff;
      end
   end

   assign found     = found_ff;
   assign best_slot = slot_ff;

endmodule

/* hw/rtl/preemptive_priority_scheduler.sv */
// Load: written into the task table at the transfer edge.
// Tick: the sequencer goes through scan, last and decide, then preempt when a running task
// is preempted, then the result state; no new request is taken until idle. The table read
// port sweeps one slot a cycle, and a tick holds in its result state until the previous
// result has gone out. Reset clears time, running task, valid and has-run bits; table
// contents are undefined until loaded and need no clearing pass.
`include "preemptive_priority_scheduler_macros.svh"

module preemptive_priority_scheduler #(
   parameter int NUM_TASKS = 16,
   parameter int TIME_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [3:0]  req_slot,
   input  logic [15:0] req_arrival,
   input  logic [15:0] req_burst,
   input  logic [7:0]  req_prio,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_idle,
   output logic [3:0]  rsp_running_slot,
   output logic        rsp_done_res,
   output logic [15:0] rsp_turnaround,
   output logic [15:0] rsp_waiting,
   output logic [15:0] rsp_response,
   output logic [15:0] rsp_now
);
   import pps_pkg::*;

   localparam int SLOT_BITS = $clog2(NUM_TASKS);
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(NUM_TASKS - 1);
   localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;

   typedef struct packed {
      logic [TIME_BITS-1:0] orig;
      logic [TIME_BITS-1:0] eff;
      logic [TIME_BITS-1:0] burst;
      logic [TIME_BITS-1:0] rem;
      logic [PRIO_BITS-1:0] prio;
      logic [TIME_BITS-1:0] first;
   } task_row_type;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_SCAN    = 6'b000010,
      ST_LAST    = 6'b000100,
      ST_DECIDE  = 6'b001000,
      ST_PREEMPT = 6'b010000,
      ST_RESP    = 6'b100000
   } state_type;

   task_row_type task_mem [NUM_TASKS];

   state_type            state_ff, state_in;
   logic [SLOT_BITS-1:0] cnt_ff, rd_slot_ff, cur_slot_ff, chose_ff;
   logic                 rd_vld_ff;
   task_row_type         rd_row_ff, best_row_ff, cur_row_ff;
   logic [NUM_TASKS-1:0] task_valid_ff, has_run_ff;
   logic [TIME_BITS-1:0] time_ff, time_next;
   logic                 cur_valid_ff, cur_rdy_ff;
   logic                 run_ff, done_ff;
   logic [TIME_BITS-1:0] ta_ff, wt_ff, rs_ff;

   logic                 rsp_valid_ff, rsp_idle_ff, rsp_done_ff;
   logic [3:0]           rsp_slot_ff;
   logic [15:0]          rsp_ta_ff, rsp_wt_ff, rsp_rs_ff, rsp_now_ff;

   logic                 req_acc, tick_acc, load_acc, slot_ok, rsp_fire;
   logic [31:0]          slot_ext, arr_ext, bur_ext;
   logic [SLOT_BITS-1:0] ld_slot;
   logic [TIME_BITS-1:0] ld_arr, ld_bur;

   logic                 rd_rdy, take, sel_found;
   logic [SLOT_BITS-1:0] sel_slot;
   scan_ctl_type         scan_ctl;

   logic                 cur_ok, preempt;
   logic [SLOT_BITS-1:0] ch_slot;
   task_row_type         ch_row;
   logic [TIME_BITS-1:0] ch_first, ch_rem, ch_ta, ch_wt, ch_rs;

   logic                 wr_en;
   logic [SLOT_BITS-1:0] wr_addr;
   task_row_type         wr_row;

   logic [31:0]          ch_ext, ta_ext, wt_ext, rs_ext, now_ext;

   // request decode
   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign tick_acc  = req_acc && (req_func == FUNC_TICK);
   assign slot_ext  = 32'(req_slot);
   assign slot_ok   = slot_ext < 32'(NUM_TASKS);
   assign load_acc  = req_acc && (req_func == FUNC_LOAD) && slot_ok;
   assign ld_slot   = slot_ext[SLOT_BITS-1:0];
   assign arr_ext   = 32'(req_arrival);
   assign bur_ext   = 32'(req_burst);
   assign ld_arr    = arr_ext[TIME_BITS-1:0];
   assign ld_bur    = bur_ext[TIME_BITS-1:0];

   // saturating time step
   assign time_next = (time_ff < TIME_MAX) ? time_ff + TIME_BITS'(1) : TIME_MAX;

   // candidate from the scan read port
   assign rd_rdy         = task_valid_ff[rd_slot_ff] && (rd_row_ff.eff <= time_ff);
   assign scan_ctl.clear = tick_acc;
   assign scan_ctl.cand  = rd_vld_ff && rd_rdy;

   pps_select #(
      .SLOT_BITS (SLOT_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_select (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .cand_slot (rd_slot_ff),
      .cand_prio (rd_row_ff.prio),
      .cand_eff  (rd_row_ff.eff),
      .take      (take),
      .found     (sel_found),
      .best_slot (sel_slot)
   );

   // decision: running task keeps the cpu on a priority tie
   assign cur_ok   = cur_valid_ff && cur_rdy_ff && (cur_row_ff.prio <= best_row_ff.prio);
   assign ch_slot  = cur_ok ? cur_slot_ff : sel_slot;
   assign ch_row   = cur_ok ? cur_row_ff : best_row_ff;
   assign ch_first = has_run_ff[ch_slot] ? ch_row.first : time_ff;
   assign ch_rem   = ch_row.rem - TIME_BITS'(1);
   assign ch_ta    = time_next - ch_row.orig;
   assign ch_wt    = (ch_ta >= ch_row.burst) ? ch_ta - ch_row.burst : '0;
   assign ch_rs    = ch_first - ch_row.orig;
   assign preempt  = cur_valid_ff && (cur_slot_ff != ch_slot) && task_valid_ff[cur_slot_ff];
   assign rsp_fire = !rsp_valid_ff || rsp_ready;

   // table write port: load, chosen task update, preempted task update
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ch_slot;
      wr_row  = ch_row;
      if (load_acc) begin
         wr_en   = 1'b1;
         wr_addr = ld_slot;
         wr_row  = '{orig: ld_arr, eff: ld_arr, burst: ld_bur, rem: ld_bur,
                     prio: req_prio, first: '0};
      end else if ((state_ff == ST_DECIDE) && sel_found) begin
         wr_en        = 1'b1;
         wr_row.first = ch_first;
         wr_row.rem   = ch_rem;
      end else if (state_ff == ST_PREEMPT) begin
         wr_en      = 1'b1;
         wr_addr    = cur_slot_ff;
         wr_row     = cur_row_ff;
         wr_row.eff = time_ff;
      end
   end

   // task table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         task_mem[wr_addr] <= wr_row;
      end
      rd_row_ff <= task_mem[cnt_ff];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (tick_acc) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == LAST_SLOT) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = (sel_found && preempt) ? ST_PREEMPT : ST_RESP;
         end
         ST_PREEMPT: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         task_valid_ff <= '0;
         has_run_ff    <= '0;
         time_ff       <= '0;
         cur_slot_ff   <= '0;
         cur_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= (state_ff == ST_SCAN);
         if (tick_acc) begin
            cnt_ff <= '0;
         end else if ((state_ff == ST_SCAN) && (cnt_ff != LAST_SLOT)) begin
            cnt_ff <= cnt_ff + SLOT_BITS'(1);
         end
         if (state_ff == ST_SCAN) begin
            rd_slot_ff <= cnt_ff;
         end
         if (load_acc) begin
            task_valid_ff[ld_slot] <= (ld_bur != '0);
            has_run_ff[ld_slot]    <= 1'b0;
            if (cur_valid_ff && (cur_slot_ff == ld_slot)) begin
               cur_valid_ff <= 1'b0;
            end
         end
         if ((state_ff == ST_DECIDE) && sel_found) begin
            has_run_ff[ch_slot] <= 1'b1;
            if (ch_rem == '0) begin
               task_valid_ff[ch_slot] <= 1'b0;
            end
         end
         if ((state_ff == ST_RESP) && rsp_fire) begin
            rsp_valid_ff <= 1'b1;
            time_ff      <= time_next;
            if (run_ff) begin
               cur_valid_ff <= !done_ff;
               cur_slot_ff  <= chose_ff;
            end
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // scan capture and decision results
   always_ff @(posedge clock) begin
      if (take) begin
         best_row_ff <= rd_row_ff;
      end
      if (rd_vld_ff && (rd_slot_ff == cur_slot_ff)) begin
         cur_row_ff <= rd_row_ff;
         cur_rdy_ff <= rd_rdy;
      end
      if (state_ff == ST_DECIDE) begin
         chose_ff <= ch_slot;
         run_ff   <= sel_found;
         done_ff  <= sel_found && (ch_rem == '0);
         ta_ff    <= ch_ta;
         wt_ff    <= ch_wt;
         rs_ff    <= ch_rs;
      end
   end

   // result register
   assign ch_ext  = 32'(chose_ff);
   assign ta_ext  = 32'(ta_ff);
   assign wt_ext  = 32'(wt_ff);
   assign rs_ext  = 32'(rs_ff);
   assign now_ext = 32'(time_next);

   always_ff @(posedge clock) begin
      if ((state_ff == ST_RESP) && rsp_fire) begin
         rsp_idle_ff <= !run_ff;
         rsp_slot_ff <= run_ff ? ch_ext[3:0] : 4'd0;
         rsp_done_ff <= done_ff;
         rsp_ta_ff   <= done_ff ? ta_ext[15:0] : 16'd0;
         rsp_wt_ff   <= done_ff ? wt_ext[15:0] : 16'd0;
         rsp_rs_ff   <= done_ff ? rs_ext[15:0] : 16'd0;
         rsp_now_ff  <= now_ext[15:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_idle         = rsp_idle_ff;
   assign rsp_running_slot = rsp_slot_ff;
   assign rsp_done_res     = rsp_done_ff;
   assign rsp_turnaround   = rsp_ta_ff;
   assign rsp_waiting      = rsp_wt_ff;
   assign rsp_response     = rsp_rs_ff;
   assign rsp_now          = rsp_now_ff;

   // checks
   `PPS_ASSERT_SAME(a_cur_is_live, (state_ff == ST_IDLE) && cur_valid_ff,
      task_valid_ff[cur_slot_ff], "running task is not a live table entry")
   `PPS_ASSERT_SAME(a_chosen_is_live, (state_ff == ST_DECIDE) && sel_found,
      task_valid_ff[ch_slot], "chosen task is not a live table entry")
   `PPS_ASSERT_SAME(a_idle_not_done, rsp_valid_ff && rsp_idle_ff,
      !rsp_done_ff, "idle tick reports a completion")
   `PPS_ASSERT_NEXT(a_preempt_then_resp, state_ff == ST_PREEMPT,
      state_ff == ST_RESP, "preempt write not followed by result")

endmodule
